// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the tuning word command generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked after reset has been released.
`define DDSTW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Checked at every edge, reset included.
`define DDSTW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DDSTW_ASSERT(lbl, clk, rstn, prop)
`define DDSTW_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== src/ddstw_pkg.sv =====
// Types and constants shared by the tuning word command generator modules.
`default_nettype none

package ddstw_pkg;

  localparam int unsigned MCLK_W = 27;
  localparam int unsigned FMAX_W = 26;

  // Command opcodes
  localparam logic [2:0] OP_WR_FREQ   = 3'd0;
  localparam logic [2:0] OP_WR_PHASE  = 3'd1;
  localparam logic [2:0] OP_PINGPONG  = 3'd2;
  localparam logic [2:0] OP_INIT      = 3'd3;
  localparam logic [2:0] OP_SEL_FREQ  = 3'd4;
  localparam logic [2:0] OP_SEL_PHASE = 3'd5;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_FREQ  = 2'd1;
  localparam logic [1:0] STATUS_BAD_PHASE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MCLK = 1'b0;
  localparam logic CFG_FMAX = 1'b1;

  localparam logic [MCLK_W-1:0] MCLK_RESET = 27'd75000000;
  localparam logic [FMAX_W-1:0] FMAX_RESET = 26'd37500000;

  // Serial command words and register addresses
  localparam logic [15:0] CMD_RESET = 16'h2300;
  localparam logic [15:0] CMD_RUN   = 16'h2200;
  localparam logic [15:0] ADDR_F0   = 16'h4000;
  localparam logic [15:0] ADDR_F1   = 16'h8000;
  localparam logic [15:0] ADDR_P0   = 16'hC000;
  localparam logic [15:0] ADDR_P1   = 16'hE000;
  localparam int unsigned DATA_BITS = 14;

  // Phase word: (deg * 4096 + 180) / 360
  localparam int unsigned PHASE_SHIFT = 12;
  localparam int unsigned PHASE_ROUND = 180;
  localparam int unsigned PHASE_DIV   = 360;
  localparam int unsigned PHASE_MAX   = 359;
  localparam int unsigned DEG_W       = 9;

  // Same value as (deg * 1024 + 45) / 90, taken as (n * 745655) >> 26;
  // exact for every n below 2^19
  localparam logic [9:0]  PHASE_NUM_LO = 10'd45;
  localparam logic [19:0] PHASE_RECIP  = 20'd745655;
  localparam int unsigned PHASE_RSH    = 26;

  typedef enum logic [3:0] {
    K_NONE,
    K_FREQ_LO,
    K_FREQ_HI,
    K_PHASE,
    K_PHASE0,
    K_PHASE1,
    K_RESET,
    K_RUN,
    K_ERR_FREQ,
    K_ERR_PHASE
  } kind_e;

  typedef enum logic [2:0] {
    PIN_HOLD,
    PIN_CLEAR,
    PIN_FLIP,
    PIN_SET_F,
    PIN_SET_P
  } pin_e;

  typedef struct packed {
    logic  accept;
    logic  div_start;
    logic  emit;
    kind_e kind;
    logic  wreg;
    logic  last;
    pin_e  pin;
  } ddstw_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       reg_index;
    logic       freq_ok;
    logic       phase_ok;
    logic       active;
    logic       div_busy;
    logic       slot_free;
  } ddstw_sts_t;

endpackage

`default_nettype wire

// ===== src/dds_tuning_word_command_generator.sv =====
// Top level of the DDS tuning word command generator.
// One request in, one to eight serial command words out, each with the select pin levels,
// a status code and tlast on the final result of the request. Frequency words come from a
// restoring divider that yields one quotient bit per cycle, so a request that needs a
// division has its first result registered once the divider is done and the result
// register is free, then one result per cycle while the output is taken; once the last
// word of a request is registered, the next request can be accepted in the next cycle.
// Phase words use a constant reciprocal multiplication; phase, select, error and
// unused-opcode requests need no division and go from the start state straight to the
// emit state. One request is worked on at a time; the result register lets the next
// request in while the last result still waits.
`default_nettype none

module dds_tuning_word_command_generator import ddstw_pkg::*; #(
  parameter int unsigned TUNING_BITS = 28
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [MCLK_W-1:0] cfg_data_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] frequency in Hz, [47:32] phase in degrees
  input  wire logic [47:0]       s_axis_tdata,
  // [2:0] op, [3] reg_index
  input  wire logic [3:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [15:0] spi_word, [16] word_valid, [17] freq_select, [18] phase_select,
  // [20:19] status, [23:21] zero
  output logic [23:0]            m_axis_tdata,
  output logic                   m_axis_tlast
);

  ddstw_cmd_t  cmd;
  ddstw_sts_t  sts;
  logic [15:0] spi_word;
  logic        word_valid, freq_select, phase_select;
  logic [1:0]  status;

  ddstw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ddstw_datapath #(
    .TUNING_BITS (TUNING_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (s_axis_tuser[2:0]),
    .reg_index_i    (s_axis_tuser[3]),
    .freq_i         (s_axis_tdata[31:0]),
    .deg_i          (s_axis_tdata[47:32]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .spi_word_o     (spi_word),
    .word_valid_o   (word_valid),
    .freq_select_o  (freq_select),
    .phase_select_o (phase_select),
    .status_o       (status),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, status, phase_select, freq_select, word_valid, spi_word};

endmodule

`default_nettype wire

// ===== src/ddstw_divider.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
`default_nettype none

module ddstw_divider #(
  parameter int unsigned NUM_W = 55,
  parameter int unsigned DEN_W = 27
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic      [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    ge     = ~diff[DEN_W+1];
    rem_d  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    quo_d  = {quo_q[NUM_W-2:0], ge};
    cnt_d  = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(NUM_W);
    end else if (busy_o) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_o) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== src/ddstw_datapath.sv =====
// Datapath: command fields, configuration, divider, pin state and result register.
`default_nettype none

module ddstw_datapath import ddstw_pkg::*; #(
  parameter int unsigned TUNING_BITS = 28
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [MCLK_W-1:0] cfg_data_i,
  input  wire logic [2:0]        op_i,
  input  wire logic              reg_index_i,
  input  wire logic [31:0]       freq_i,
  input  wire logic [15:0]       deg_i,
  input  wire ddstw_cmd_t        cmd_i,
  output ddstw_sts_t             sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [15:0]            spi_word_o,
  output logic                   word_valid_o,
  output logic                   freq_select_o,
  output logic                   phase_select_o,
  output logic [1:0]             status_o,
  output logic                   last_o
);

  localparam int unsigned NUM_W = FMAX_W + TUNING_BITS + 1;

  logic [MCLK_W-1:0] mclk_q;
  logic [FMAX_W-1:0] fmax_q;
  logic [2:0]        op_q;
  logic              reg_q;
  logic [FMAX_W-1:0] freq_q;
  logic [DEG_W-1:0]  deg_q;
  logic              fok_q, pok_q;
  logic              active_q, fsel_q, psel_q;
  logic              active_d, fsel_d, psel_d;
  logic              out_valid_q;

  logic [NUM_W-1:0]  div_num;
  logic [MCLK_W-1:0] div_den;
  logic [NUM_W-1:0]  quo;
  logic              div_busy;

  logic [DEG_W+9:0]  ph_num;
  logic [DEG_W+29:0] ph_prod;
  logic [11:0]       ph_word;

  logic [15:0]       word_d;
  logic              wvalid_d;
  logic [1:0]        status_d;
  logic [15:0]       faddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mclk_q <= MCLK_RESET;
      fmax_q <= FMAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MCLK: mclk_q <= cfg_data_i;
        CFG_FMAX: fmax_q <= cfg_data_i[FMAX_W-1:0];
        default:  ;
      endcase
    end
  end

  // Hold the request fields and their range checks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= '0;
      reg_q <= 1'b0;
      fok_q <= 1'b0;
      pok_q <= 1'b0;
    end else if (cmd_i.accept) begin
      op_q  <= op_i;
      reg_q <= reg_index_i;
      fok_q <= (freq_i != '0) && (freq_i <= 32'(fmax_q));
      pok_q <= (deg_i <= 16'(PHASE_MAX));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      freq_q <= freq_i[FMAX_W-1:0];
      deg_q  <= deg_i[DEG_W-1:0];
    end
  end

  always_comb begin
    div_num = {1'b0, freq_q, {TUNING_BITS{1'b0}}} + NUM_W'(mclk_q >> 1);
    div_den = (mclk_q == '0) ? MCLK_W'(1) : mclk_q;
  end

  ddstw_divider #(
    .NUM_W (NUM_W),
    .DEN_W (MCLK_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // Phase word by reciprocal multiplication of the reduced fraction
  always_comb begin
    ph_num  = {deg_q, PHASE_NUM_LO};
    ph_prod = {20'd0, ph_num} * {19'd0, PHASE_RECIP};
    ph_word = ph_prod[PHASE_RSH+PHASE_SHIFT-1:PHASE_RSH];
  end

  // Pin levels shown with a result already include that result's update
  always_comb begin
    active_d = active_q;
    fsel_d   = fsel_q;
    psel_d   = psel_q;
    case (cmd_i.pin)
      PIN_CLEAR: begin
        fsel_d = 1'b0;
        psel_d = 1'b0;
      end
      PIN_FLIP: begin
        active_d = ~active_q;
        fsel_d   = ~active_q;
      end
      PIN_SET_F: fsel_d = reg_q;
      PIN_SET_P: psel_d = reg_q;
      default:   ;
    endcase
  end

  always_comb begin
    faddr    = cmd_i.wreg ? ADDR_F1 : ADDR_F0;
    word_d   = '0;
    wvalid_d = 1'b1;
    status_d = STATUS_OK;
    case (cmd_i.kind)
      K_FREQ_LO: word_d = faddr | {2'b00, quo[DATA_BITS-1:0]};
      K_FREQ_HI: word_d = faddr | {2'b00, quo[2*DATA_BITS-1:DATA_BITS]};
      K_PHASE:   word_d = (reg_q ? ADDR_P1 : ADDR_P0) | {4'b0000, ph_word};
      K_PHASE0:  word_d = ADDR_P0;
      K_PHASE1:  word_d = ADDR_P1;
      K_RESET:   word_d = CMD_RESET;
      K_RUN:     word_d = CMD_RUN;
      K_ERR_FREQ: begin
        wvalid_d = 1'b0;
        status_d = STATUS_BAD_FREQ;
      end
      K_ERR_PHASE: begin
        wvalid_d = 1'b0;
        status_d = STATUS_BAD_PHASE;
      end
      default: wvalid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      fsel_q      <= 1'b0;
      psel_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        active_q    <= active_d;
        fsel_q      <= fsel_d;
        psel_q      <= psel_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      spi_word_o     <= word_d;
      word_valid_o   <= wvalid_d;
      freq_select_o  <= fsel_d;
      phase_select_o <= psel_d;
      status_o       <= status_d;
      last_o         <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.op        = op_q;
    sts_o.reg_index = reg_q;
    sts_o.freq_ok   = fok_q;
    sts_o.phase_ok  = pok_q;
    sts_o.active    = active_q;
    sts_o.div_busy  = div_busy;
    sts_o.slot_free = ~out_valid_q | out_ready_i;
  end

endmodule

`default_nettype wire

// ===== src/ddstw_ctrl.sv =====
// Controller: accepts a request, runs the divider and sequences the result words.
`default_nettype none

`include "assert_macros.svh"

module ddstw_ctrl import ddstw_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output logic            s_ready_o,
  input  wire ddstw_sts_t sts_i,
  output ddstw_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       need_div;

  always_comb begin
    need_div = (sts_i.op inside {OP_WR_FREQ, OP_PINGPONG, OP_INIT}) && sts_i.freq_ok;
  end

  // Result sequence for each opcode
  always_comb begin
    cmd_o.kind = K_NONE;
    cmd_o.wreg = 1'b0;
    cmd_o.last = 1'b1;
    cmd_o.pin  = PIN_HOLD;
    case (sts_i.op)
      OP_WR_FREQ: begin
        if (!sts_i.freq_ok) begin
          cmd_o.kind = K_ERR_FREQ;
        end else begin
          cmd_o.kind = step_q[0] ? K_FREQ_HI : K_FREQ_LO;
          cmd_o.last = step_q[0];
          cmd_o.wreg = sts_i.reg_index;
        end
      end
      OP_WR_PHASE: cmd_o.kind = sts_i.phase_ok ? K_PHASE : K_ERR_PHASE;
      OP_PINGPONG: begin
        cmd_o.wreg = ~sts_i.active;
        if (!sts_i.freq_ok) begin
          cmd_o.kind = K_ERR_FREQ;
        end else begin
          case (step_q)
            3'd0: begin
              cmd_o.kind = K_FREQ_LO;
              cmd_o.last = 1'b0;
            end
            3'd1: begin
              cmd_o.kind = K_FREQ_HI;
              cmd_o.last = 1'b0;
            end
            default: cmd_o.pin = PIN_FLIP;
          endcase
        end
      end
      OP_INIT: begin
        cmd_o.last = 1'b0;
        case (step_q)
          3'd0: begin
            cmd_o.kind = K_RESET;
            cmd_o.pin  = PIN_CLEAR;
          end
          3'd1: begin
            cmd_o.kind = sts_i.freq_ok ? K_FREQ_LO : K_ERR_FREQ;
            cmd_o.last = ~sts_i.freq_ok;
          end
          3'd2: cmd_o.kind = K_FREQ_HI;
          3'd3: begin
            cmd_o.kind = K_FREQ_LO;
            cmd_o.wreg = 1'b1;
          end
          3'd4: begin
            cmd_o.kind = K_FREQ_HI;
            cmd_o.wreg = 1'b1;
          end
          3'd5: cmd_o.kind = K_PHASE0;
          3'd6: cmd_o.kind = K_PHASE1;
          default: begin
            cmd_o.kind = K_RUN;
            cmd_o.last = 1'b1;
          end
        endcase
      end
      OP_SEL_FREQ:  cmd_o.pin = PIN_SET_F;
      OP_SEL_PHASE: cmd_o.pin = PIN_SET_P;
      default: ;
    endcase

    state_d         = state_q;
    step_d          = step_q;
    s_ready_o       = 1'b0;
    cmd_o.accept    = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.emit      = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
        if (s_valid_i) begin
          step_d  = '0;
          state_d = S_START;
        end
      end
      S_START: begin
        if (need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_WAIT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (cmd_o.last) begin
            state_d = S_IDLE;
          end else begin
            step_d = step_q + 3'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  `DDSTW_ASSERT(a_emit_needs_slot, clk_i, rst_ni, cmd_o.emit |-> sts_i.slot_free)
  `DDSTW_ASSERT(a_start_sets_busy, clk_i, rst_ni, cmd_o.div_start |=> sts_i.div_busy)
  `DDSTW_ASSERT(a_last_ends_cmd, clk_i, rst_ni, (cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE))
  `DDSTW_ASSERT_ALWAYS(a_accept_idle_only, clk_i, cmd_o.accept |-> (state_q == S_IDLE))

endmodule

`default_nettype wire

// ===== tb/tb_dds_tuning_word_command_generator.sv =====
// Testbench for the DDS tuning word command generator: stream driver, monitor and predictor.
`default_nettype none

module tb_dds_tuning_word_command_generator;
  import ddstw_pkg::*;

  localparam int unsigned TW_BITS     = 28;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned END_SETTLE  = 100;

  // Spare opcodes the block must answer with a single empty result
  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic        rg;
    logic [31:0] freq;
    logic [15:0] deg;
  } dds_cmd_t;

  // Laid out so that {tdata, tlast} casts straight onto it
  typedef struct packed {
    logic [2:0]  pad;
    logic [1:0]  status;
    logic        phase_sel;
    logic        freq_sel;
    logic        word_valid;
    logic [15:0] spi_word;
    logic        last;
  } dds_word_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic              cfg_idx_i     = CFG_MCLK;
  logic [MCLK_W-1:0] cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [47:0]       s_axis_tdata  = '0;
  logic [3:0]        s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic              m_axis_tlast;

  dds_tuning_word_command_generator #(
    .TUNING_BITS(TW_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial forever #4 clk_i = ~clk_i;

  // Shadow copy of the block's configuration and pin state
  logic [MCLK_W-1:0] mdl_mclk   = MCLK_RESET;
  logic [FMAX_W-1:0] mdl_fmax   = FMAX_RESET;
  logic              mdl_active = 1'b0;
  logic              mdl_fsel   = 1'b0;
  logic              mdl_psel   = 1'b0;

  dds_cmd_t  cmd_backlog[$];
  dds_word_t dds_words_due[$];

  int unsigned cmds_queued = 0;
  int unsigned cmds_sent   = 0;
  int unsigned words_seen  = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned op_count[8];
  int unsigned src_gap     = 0;
  int unsigned sink_gap    = 0;
  logic        req_taken   = 1'b0;
  logic        calm        = 1'b0;

  function automatic void push_word(logic [15:0] word, logic valid, logic [1:0] status,
                                    logic last);
    dds_word_t w;
    w.pad        = '0;
    w.status     = status;
    w.phase_sel  = mdl_psel;
    w.freq_sel   = mdl_fsel;
    w.word_valid = valid;
    w.spi_word   = word;
    w.last       = last;
    dds_words_due.push_back(w);
  endfunction

  function automatic logic [63:0] calc_ftw(logic [31:0] f);
    logic [63:0] div;
    // a zero master clock divides by one
    div = (mdl_mclk == '0) ? 64'd1 : 64'(mdl_mclk);
    return ((64'(f) << TW_BITS) + div / 2) / div;
  endfunction

  function automatic logic [15:0] calc_pow(logic [15:0] deg);
    return 16'(((32'(deg) << PHASE_SHIFT) + PHASE_ROUND) / PHASE_DIV);
  endfunction

  function automatic void push_freq(logic rg, logic [31:0] f, logic last);
    logic [63:0] tw;
    logic [15:0] addr;
    tw   = calc_ftw(f);
    addr = rg ? ADDR_F1 : ADDR_F0;
    push_word(addr | {2'b00, tw[13:0]}, 1'b1, STATUS_OK, 1'b0);
    push_word(addr | {2'b00, tw[27:14]}, 1'b1, STATUS_OK, last);
  endfunction

  function automatic void predict_command(logic [2:0] op, logic rg, logic [31:0] f,
                                          logic [15:0] deg);
    logic f_ok;
    logic other;
    f_ok = (f != '0) && (f <= {6'd0, mdl_fmax});
    case (op)
      OP_WR_FREQ: begin
        if (!f_ok) push_word('0, 1'b0, STATUS_BAD_FREQ, 1'b1);
        else push_freq(rg, f, 1'b1);
      end
      OP_WR_PHASE: begin
        if (deg > PHASE_MAX) push_word('0, 1'b0, STATUS_BAD_PHASE, 1'b1);
        else push_word((rg ? ADDR_P1 : ADDR_P0) | calc_pow(deg), 1'b1, STATUS_OK, 1'b1);
      end
      OP_PINGPONG: begin
        if (!f_ok) begin
          push_word('0, 1'b0, STATUS_BAD_FREQ, 1'b1);
        end else begin
          other = ~mdl_active;
          push_freq(other, f, 1'b0);
          mdl_fsel   = other;
          mdl_active = other;
          push_word('0, 1'b0, STATUS_OK, 1'b1);
        end
      end
      OP_INIT: begin
        mdl_fsel = 1'b0;
        mdl_psel = 1'b0;
        push_word(CMD_RESET, 1'b1, STATUS_OK, 1'b0);
        if (!f_ok) begin
          push_word('0, 1'b0, STATUS_BAD_FREQ, 1'b1);
        end else begin
          push_freq(1'b0, f, 1'b0);
          push_freq(1'b1, f, 1'b0);
          push_word(ADDR_P0 | calc_pow('0), 1'b1, STATUS_OK, 1'b0);
          push_word(ADDR_P1 | calc_pow('0), 1'b1, STATUS_OK, 1'b0);
          push_word(CMD_RUN, 1'b1, STATUS_OK, 1'b1);
        end
      end
      OP_SEL_FREQ: begin
        mdl_fsel = rg;
        push_word('0, 1'b0, STATUS_OK, 1'b1);
      end
      OP_SEL_PHASE: begin
        mdl_psel = rg;
        push_word('0, 1'b0, STATUS_OK, 1'b1);
      end
      default: push_word('0, 1'b0, STATUS_OK, 1'b1);
    endcase
  endfunction

  task automatic queue_cmd(logic [2:0] op, logic rg, logic [31:0] f, logic [15:0] deg);
    dds_cmd_t c;
    c.op   = op;
    c.rg   = rg;
    c.freq = f;
    c.deg  = deg;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endtask

  task automatic queue_random(int unsigned n);
    logic [2:0]  op;
    logic [31:0] f;
    logic [15:0] deg;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3:  op = OP_WR_FREQ;
        4, 5, 6:     op = OP_WR_PHASE;
        7, 8, 9, 10: op = OP_PINGPONG;
        11, 12, 13:  op = OP_INIT;
        14, 15:      op = OP_SEL_FREQ;
        16, 17:      op = OP_SEL_PHASE;
        18:          op = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
        default:     op = OP_PINGPONG;
      endcase
      case ($urandom_range(0, 11))
        0:       f = '0;
        1:       f = $urandom;
        2:       f = {6'd0, mdl_fmax} + 32'($urandom_range(1, 1000));
        3:       f = {6'd0, mdl_fmax};
        4:       f = 32'd1;
        default: f = $urandom_range(1, mdl_fmax);
      endcase
      case ($urandom_range(0, 7))
        0:       deg = 16'($urandom);
        1:       deg = 16'(PHASE_MAX);
        2:       deg = 16'(PHASE_MAX + 1);
        default: deg = 16'($urandom_range(0, PHASE_MAX));
      endcase
      queue_cmd(op, 1'($urandom_range(0, 1)), f, deg);
    end
  endtask

  // Hold until every queued request is taken and every word has come back
  task automatic wait_drained();
    while (cmds_sent != cmds_queued || dds_words_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [MCLK_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Request driver
  always @(negedge clk_i) begin
    dds_cmd_t nxt;
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (src_gap != 0) begin
        src_gap = src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(0, 14);
        s_axis_tvalid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nxt.deg, nxt.freq};
        s_axis_tuser  <= {nxt.rg, nxt.op};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(negedge clk_i) begin
    if (sink_gap != 0) begin
      sink_gap = sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: check results first, then predict for a request taken at this edge
  always @(posedge clk_i) begin
    dds_word_t got;
    dds_word_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d words outstanding", cycle_count,
               dds_words_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = dds_word_t'({m_axis_tdata, m_axis_tlast});
        words_seen++;
        if (dds_words_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected word %h tdata %h", got.spi_word,
                                         m_axis_tdata);
        end else begin
          want = dds_words_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp word %h v%0b fs%0b ps%0b st%0d last%0b pad%0h, ",
                       want.spi_word, want.word_valid, want.freq_sel, want.phase_sel,
                       want.status, want.last, want.pad,
                       "got word %h v%0b fs%0b ps%0b st%0d last%0b pad%0h",
                       got.spi_word, got.word_valid, got.freq_sel, got.phase_sel,
                       got.status, got.last, got.pad);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MCLK) mdl_mclk = cfg_data_i;
        else mdl_fmax = cfg_data_i[FMAX_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_command(s_axis_tuser[2:0], s_axis_tuser[3], s_axis_tdata[31:0],
                        s_axis_tdata[47:32]);
        op_count[s_axis_tuser[2:0]]++;
        cmds_sent++;
      end
      req_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset configuration
    queue_cmd(OP_WR_FREQ, 1'b0, 32'd1, '0);
    queue_cmd(OP_WR_FREQ, 1'b1, {6'd0, FMAX_RESET}, 16'hFFFF);
    queue_cmd(OP_WR_FREQ, 1'b0, '0, '0);
    queue_cmd(OP_WR_FREQ, 1'b1, {6'd0, FMAX_RESET} + 32'd1, '0);
    queue_cmd(OP_WR_FREQ, 1'b0, 32'hFFFF_FFFF, '0);
    queue_cmd(OP_WR_PHASE, 1'b0, '0, '0);
    queue_cmd(OP_WR_PHASE, 1'b1, 32'hFFFF_FFFF, 16'(PHASE_MAX));
    queue_cmd(OP_WR_PHASE, 1'b0, '0, 16'(PHASE_MAX + 1));
    queue_cmd(OP_WR_PHASE, 1'b1, '0, 16'hFFFF);
    queue_cmd(OP_PINGPONG, 1'b0, 32'd1000, '0);
    queue_cmd(OP_PINGPONG, 1'b1, 32'd12345678, '0);
    queue_cmd(OP_PINGPONG, 1'b0, '0, '0);
    queue_cmd(OP_PINGPONG, 1'b0, {6'd0, FMAX_RESET} + 32'd1, '0);
    queue_cmd(OP_SEL_FREQ, 1'b1, '0, '0);
    queue_cmd(OP_SEL_PHASE, 1'b1, '0, '0);
    // init must pull both pins low, also when its frequency is rejected
    queue_cmd(OP_INIT, 1'b0, 32'd1000000, '0);
    queue_cmd(OP_SEL_PHASE, 1'b1, '0, '0);
    queue_cmd(OP_INIT, 1'b1, '0, '0);
    queue_cmd(OP_INIT, 1'b0, {6'd0, FMAX_RESET}, '0);
    queue_cmd(OP_SEL_FREQ, 1'b0, '0, '0);
    queue_cmd(OP_SEL_PHASE, 1'b0, '0, '0);
    queue_cmd(OP_UNUSED_A, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    queue_cmd(OP_UNUSED_B, 1'b0, '0, '0);
    wait_drained();

    queue_random(120);
    wait_drained();

    // Smallest clock and frequency limit
    write_cfg(CFG_MCLK, MCLK_W'(1));
    write_cfg(CFG_FMAX, MCLK_W'(1));
    @(posedge clk_i);
    queue_random(40);
    wait_drained();

    // Widest register values
    write_cfg(CFG_MCLK, '1);
    write_cfg(CFG_FMAX, MCLK_W'({FMAX_W{1'b1}}));
    @(posedge clk_i);
    queue_random(60);
    wait_drained();

    // Zero master clock divides by one
    write_cfg(CFG_MCLK, '0);
    write_cfg(CFG_FMAX, MCLK_W'($urandom_range(1, 37500000)));
    @(posedge clk_i);
    queue_random(40);
    wait_drained();

    // Random in-range setting, no idling on either side
    write_cfg(CFG_MCLK, MCLK_W'($urandom_range(1, 75000000)));
    write_cfg(CFG_FMAX, MCLK_W'($urandom_range(1, 37500000)));
    calm = 1'b1;
    @(posedge clk_i);
    queue_random(90);
    wait_drained();

    repeat (END_SETTLE) @(posedge clk_i);
    if (dds_words_due.size() != 0) fail_count++;
    $display("%0d commands over five configurations, %0d words checked, %0d failures",
             cmds_sent, words_seen, fail_count);
    $display("per op: wf %0d wp %0d pp %0d init %0d sf %0d sp %0d spare %0d",
             op_count[OP_WR_FREQ], op_count[OP_WR_PHASE], op_count[OP_PINGPONG],
             op_count[OP_INIT], op_count[OP_SEL_FREQ], op_count[OP_SEL_PHASE],
             op_count[OP_UNUSED_A] + op_count[OP_UNUSED_B]);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/ddstw_pkg.sv
src/ddstw_divider.sv
src/ddstw_datapath.sv
src/ddstw_ctrl.sv
src/dds_tuning_word_command_generator.sv
tb/tb_dds_tuning_word_command_generator.sv
